// ----- src/efb_pkg.sv -----
// Package with the item types and fixed widths of the edge plane frame builder.
package efb_pkg;

	localparam int FRAC   = 16;
	localparam int HALF   = 1 << (FRAC - 1);
	localparam int DIV_QW = 18;
	localparam int DW     = 33;
	localparam int LW     = 34;
	localparam int NW     = 35;
	localparam int XQW    = 18;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic signed [31:0] start_normal_x;
		logic signed [31:0] start_normal_y;
		logic signed [31:0] start_normal_z;
		logic signed [31:0] end_normal_x;
		logic signed [31:0] end_normal_y;
		logic signed [31:0] end_normal_z;
	} frame_req_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] xdir_x;
		logic signed [31:0] xdir_y;
		logic signed [31:0] xdir_z;
		logic signed [31:0] plane_normal_x;
		logic signed [31:0] plane_normal_y;
		logic signed [31:0] plane_normal_z;
		logic        [31:0] edge_length;
		logic               degenerate;
	} frame_res_t;

endpackage

// ----- src/efb_req_if.sv -----
// Request channel interface carrying one edge with its endpoint normals.
interface efb_req_if import efb_pkg::*; ();
	logic       valid;
	logic       ready;
	frame_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/efb_frame_if.sv -----
// Result channel interface carrying one local plane frame.
interface efb_frame_if import efb_pkg::*; ();
	logic       valid;
	logic       ready;
	frame_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/efb_delay.sv -----
// Enabled shift line that keeps side data level with the arithmetic pipeline.
module efb_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_s [D];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= d;
			for (int k = 1; k < D; k++) begin
				sr_s[k] <= sr_s[k-1];
			end
		end
	end

	assign q = sr_s[D-1];

endmodule

// ----- src/efb_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module efb_sqrt #(
	parameter int W = 34
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] x,
	output logic [W-1:0]   root
);

	logic [2*W-1:0] rem_s [W+1];
	logic [W-1:0]   rt_s  [W+1];
	logic [2*W-1:0] rem_n [W];
	logic [W-1:0]   rt_n  [W];

	always_comb begin
		for (int j = 0; j < W; j++) begin
			logic [2*W-1:0] t;
			t = ((2*W)'(rt_s[j]) << (W - j)) | ((2*W)'(1) << (2 * (W - 1 - j)));
			if (rem_s[j] >= t) begin
				rem_n[j] = rem_s[j] - t;
				rt_n[j]  = rt_s[j] | (W'(1) << (W - 1 - j));
			end else begin
				rem_n[j] = rem_s[j];
				rt_n[j]  = rt_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= x;
			rt_s[0]  <= '0;
			for (int j = 0; j < W; j++) begin
				rem_s[j+1] <= rem_n[j];
				rt_s[j+1]  <= rt_n[j];
			end
		end
	end

	assign root = rt_s[W];

endmodule

// ----- src/efb_div.sv -----
// Pipelined restoring divider with round half away from zero and sign restore.
module efb_div import efb_pkg::*; #(
	parameter int AW = 50,
	parameter int DVW = 34
) (
	input  logic                clk,
	input  logic                en,
	input  logic                neg,
	input  logic [AW-1:0]       a,
	input  logic [DVW-1:0]      d,
	output logic signed [31:0]  q
);

	localparam int RW = DVW + DIV_QW;

	logic [RW-1:0]     rem_s [DIV_QW+1];
	logic [DVW-1:0]    dv_s  [DIV_QW+1];
	logic              ng_s  [DIV_QW+1];
	logic [DIV_QW-1:0] qt_s  [DIV_QW+1];
	logic [RW-1:0]     rem_n [DIV_QW];
	logic              ge    [DIV_QW];
	logic [DIV_QW:0]   qr;
	logic [31:0]       qm;

	always_comb begin
		for (int j = 0; j < DIV_QW; j++) begin
			logic [RW-1:0] sh;
			sh       = RW'(dv_s[j]) << (DIV_QW - 1 - j);
			ge[j]    = rem_s[j] >= sh;
			rem_n[j] = ge[j] ? rem_s[j] - sh : rem_s[j];
		end
		qr = ((DIV_QW+1)'(qt_s[DIV_QW]) + (DIV_QW+1)'(1)) >> 1;
		qm = 32'(qr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(a);
			dv_s[0]  <= d;
			ng_s[0]  <= neg;
			qt_s[0]  <= '0;
			for (int j = 0; j < DIV_QW; j++) begin
				rem_s[j+1] <= rem_n[j];
				dv_s[j+1]  <= dv_s[j];
				ng_s[j+1]  <= ng_s[j];
				qt_s[j+1]  <= {qt_s[j][DIV_QW-2:0], ge[j]};
			end
			q <= ng_s[DIV_QW] ? -$signed(qm) : $signed(qm);
		end
	end

endmodule

// ----- src/edge_plane_frame_builder.sv -----
// Top level of the edge plane frame builder pipeline.
// The req channel takes one edge per item: start and end points and the surface
// normals at both ends, all signed Q16.16. The frame channel returns one item per
// request, in order: origin, unit edge direction, unit plane normal, the edge
// length saturated to 32 bits, and a degenerate flag.
// The datapath is a fixed pipeline: edge vector and squares, a 35 stage square
// root, 20 stage dividers for the edge direction, the projection of the normal
// sum, a 36 stage square root and 20 stage dividers for the plane normal.
// A new item is taken every cycle while the receiver keeps up; throughput is
// then one frame per cycle. When the receiver stalls the result waits in the
// output register, and the pipeline keeps moving while its last stage is empty,
// so bubbles close up before req.ready falls. A stall loses or repeats nothing.
// Reset clears all valid bits and the output valid flag, so items in flight are
// dropped. Degenerate frames carry zero direction vectors.
module edge_plane_frame_builder import efb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	efb_req_if.sink    req,
	efb_frame_if.source frame
);

	localparam int XAW   = DW + FRAC + 1;
	localparam int PAW   = NW + FRAC + 1;
	localparam int T_LEN = 4 + LW + 1;
	localparam int T_XD  = T_LEN + DIV_QW + 2;
	localparam int T_R   = T_XD + 8;
	localparam int T_RS  = T_XD + 10;
	localparam int T_N   = T_RS + NW + 1;
	localparam int T_PN  = T_N + DIV_QW + 2;

	logic              en;
	logic [T_PN-1:0]   vld_s;
	logic              ov_q;
	logic              ld;
	frame_res_t        res;

	logic signed [31:0] st_in [3];
	logic signed [31:0] ep_in [3];
	logic signed [31:0] sn_in [3];
	logic signed [31:0] nn_in [3];

	logic signed [32:0] d_s1  [3];
	logic signed [32:0] s_s1  [3];
	logic [DW-1:0]      dm_s2 [3];
	logic               dn_s2 [3];
	logic [2*DW-1:0]    sq_s3 [3];
	logic [2*LW-1:0]    ss_s4;

	logic [LW-1:0]      len;
	logic [3*(DW+1)-1:0] dmd_in, dmd_out;
	logic signed [31:0] xd [3];
	logic [3*33-1:0]    sx_in, sx_out, s5_out;
	logic signed [32:0] s_x [3];
	logic signed [32:0] s_5 [3];

	logic signed [50:0] pd_s5 [3];
	logic signed [52:0] acc_s6;
	logic [52:0]        am_s7;
	logic               an_s7;
	logic signed [37:0] dot_s8;
	logic [3*XQW-1:0]   x4_in, x4_out;
	logic signed [XQW-1:0] xd4 [3];
	logic signed [55:0] pr_s9 [3];
	logic signed [56:0] df_s10 [3];
	logic [56:0]        dfm_s11 [3];
	logic               dfn_s11 [3];
	logic [NW-1:0]      rm_s12 [3];
	logic               rn_s12 [3];
	logic [2*NW-1:0]    rq_s13 [3];
	logic [2*NW-1:0]    rs_s14;

	logic [NW-1:0]      nlen;
	logic [3*(NW+1)-1:0] rmd_in, rmd_out;
	logic signed [31:0] pn [3];
	logic [LW-1:0]      len_d;
	logic               nz_d;
	logic [95:0]        st_pk, st_d, xd_pk, xd_d;
	logic [52:0]        rdot;
	logic [56:0]        rres [3];

	assign st_in = '{req.data.start_x, req.data.start_y, req.data.start_z};
	assign ep_in = '{req.data.end_x, req.data.end_y, req.data.end_z};
	assign sn_in = '{req.data.start_normal_x, req.data.start_normal_y,
		req.data.start_normal_z};
	assign nn_in = '{req.data.end_normal_x, req.data.end_normal_y, req.data.end_normal_z};

	assign en        = !vld_s[T_PN-1] || !ov_q || frame.ready;
	assign req.ready = en;
	assign ld        = vld_s[T_PN-1] && (!ov_q || frame.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[T_PN-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= 33'(ep_in[i]) - 33'(st_in[i]);
				s_s1[i]  <= 33'(sn_in[i]) + 33'(nn_in[i]);
				dm_s2[i] <= d_s1[i][32] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
				dn_s2[i] <= d_s1[i][32];
				sq_s3[i] <= dm_s2[i] * dm_s2[i];
			end
			ss_s4 <= (2*LW)'(sq_s3[0]) + (2*LW)'(sq_s3[1]) + (2*LW)'(sq_s3[2]);
		end
	end

	efb_sqrt #(.W(LW)) u_len_sqrt (.clk(clk), .en(en), .x(ss_s4), .root(len));

	assign dmd_in = {dn_s2[2], dm_s2[2], dn_s2[1], dm_s2[1], dn_s2[0], dm_s2[0]};

	efb_delay #(.W(3*(DW+1)), .D(T_LEN-2)) u_dm_dly (
		.clk(clk), .en(en), .d(dmd_in), .q(dmd_out));

	for (genvar g = 0; g < 3; g++) begin : g_xdiv
		efb_div #(.AW(XAW), .DVW(LW)) u_xdiv (
			.clk(clk), .en(en),
			.neg(dmd_out[g*(DW+1)+DW]),
			.a({dmd_out[g*(DW+1) +: DW], {(FRAC+1){1'b0}}}),
			.d(len), .q(xd[g]));
		assign s_x[g] = $signed(sx_out[g*33 +: 33]);
		assign s_5[g] = $signed(s5_out[g*33 +: 33]);
		assign xd4[g] = $signed(x4_out[g*XQW +: XQW]);
		assign rres[g] = dfm_s11[g] + 57'(HALF);
	end

	assign sx_in = {s_s1[2], s_s1[1], s_s1[0]};

	efb_delay #(.W(3*33), .D(T_XD-1)) u_s_dly (
		.clk(clk), .en(en), .d(sx_in), .q(sx_out));
	efb_delay #(.W(3*33), .D(5)) u_s5_dly (
		.clk(clk), .en(en), .d(sx_out), .q(s5_out));

	assign x4_in = {xd[2][XQW-1:0], xd[1][XQW-1:0], xd[0][XQW-1:0]};

	efb_delay #(.W(3*XQW), .D(4)) u_x4_dly (
		.clk(clk), .en(en), .d(x4_in), .q(x4_out));

	assign rdot = (am_s7 + 53'(HALF)) >> FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s5[i] <= s_x[i] * $signed(xd[i][XQW-1:0]);
			end
			acc_s6 <= 53'(pd_s5[0]) + 53'(pd_s5[1]) + 53'(pd_s5[2]);
			am_s7  <= acc_s6[52] ? 53'(-acc_s6) : 53'(acc_s6);
			an_s7  <= acc_s6[52];
			dot_s8 <= an_s7 ? -$signed(38'(rdot)) : $signed(38'(rdot));
			for (int i = 0; i < 3; i++) begin
				pr_s9[i]   <= dot_s8 * xd4[i];
				df_s10[i]  <= (57'(s_5[i]) <<< FRAC) - 57'(pr_s9[i]);
				dfm_s11[i] <= df_s10[i][56] ? 57'(-df_s10[i]) : 57'(df_s10[i]);
				dfn_s11[i] <= df_s10[i][56];
				rm_s12[i]  <= NW'(rres[i] >> FRAC);
				rn_s12[i]  <= dfn_s11[i];
				rq_s13[i]  <= rm_s12[i] * rm_s12[i];
			end
			rs_s14 <= rq_s13[0] + rq_s13[1] + rq_s13[2];
		end
	end

	efb_sqrt #(.W(NW)) u_nrm_sqrt (.clk(clk), .en(en), .x(rs_s14), .root(nlen));

	assign rmd_in = {rn_s12[2], rm_s12[2], rn_s12[1], rm_s12[1], rn_s12[0], rm_s12[0]};

	efb_delay #(.W(3*(NW+1)), .D(T_N-T_R)) u_rm_dly (
		.clk(clk), .en(en), .d(rmd_in), .q(rmd_out));

	for (genvar g = 0; g < 3; g++) begin : g_pdiv
		efb_div #(.AW(PAW), .DVW(NW)) u_pdiv (
			.clk(clk), .en(en),
			.neg(rmd_out[g*(NW+1)+NW]),
			.a({rmd_out[g*(NW+1) +: NW], {(FRAC+1){1'b0}}}),
			.d(nlen), .q(pn[g]));
	end

	assign st_pk = {st_in[2], st_in[1], st_in[0]};
	assign xd_pk = {xd[2], xd[1], xd[0]};

	efb_delay #(.W(96), .D(T_PN)) u_st_dly (
		.clk(clk), .en(en), .d(st_pk), .q(st_d));
	efb_delay #(.W(96), .D(T_PN-T_XD)) u_xd_dly (
		.clk(clk), .en(en), .d(xd_pk), .q(xd_d));
	efb_delay #(.W(LW), .D(T_PN-T_LEN)) u_len_dly (
		.clk(clk), .en(en), .d(len), .q(len_d));
	efb_delay #(.W(1), .D(T_PN-T_N)) u_nz_dly (
		.clk(clk), .en(en), .d(nlen == '0), .q(nz_d));

	always_comb begin
		res.origin_x    = st_d[31:0];
		res.origin_y    = st_d[63:32];
		res.origin_z    = st_d[95:64];
		res.degenerate  = (len_d == '0) || nz_d;
		res.edge_length = (|len_d[LW-1:32]) ? '1 : len_d[31:0];
		if (res.degenerate) begin
			res.xdir_x         = '0;
			res.xdir_y         = '0;
			res.xdir_z         = '0;
			res.plane_normal_x = '0;
			res.plane_normal_y = '0;
			res.plane_normal_z = '0;
		end else begin
			res.xdir_x         = xd_d[31:0];
			res.xdir_y         = xd_d[63:32];
			res.xdir_z         = xd_d[95:64];
			res.plane_normal_x = pn[0];
			res.plane_normal_y = pn[1];
			res.plane_normal_z = pn[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ld) begin
			ov_q <= 1'b1;
		end else if (frame.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			frame.data <= res;
		end
	end

	assign frame.valid = ov_q;

	a_ready_on_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[T_PN-1] |-> req.ready)
		else $error("request refused although the last stage is empty");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !frame.ready && vld_s[T_PN-1] |=> $stable(vld_s))
		else $error("pipeline moved while its last item could not leave");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.data.degenerate |->
		frame.data.xdir_x == 0 && frame.data.plane_normal_x == 0)
		else $error("degenerate frame with non-zero direction");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && !frame.data.degenerate |-> frame.data.edge_length != 0)
		else $error("valid frame with zero edge length");

endmodule
